/* hdl/dsot_pkg.sv */
// Shared constants and types for the DMA slot ownership tracker.
package dsot_pkg;

    localparam int SLOT_COUNT  = 32;
    localparam int SLOT_BYTES  = 65536;
    localparam int ALIGN_BYTES = 64;
    localparam int HOST_CORE   = 0;
    localparam int TOKEN_SHIFT = 32;
    localparam logic [31:0] TOKEN_MAGIC = 32'd1145913649;
    localparam logic [31:0] ARENA_BASE  = 32'h0640_0000;

    localparam int SLOT_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W   = $clog2(SLOT_COUNT + 1);
    localparam int ALIGN_W = (ALIGN_BYTES > 1) ? $clog2(ALIGN_BYTES) : 1;

    localparam logic [2:0] OP_ACQUIRE  = 3'd0;
    localparam logic [2:0] OP_PUBLISH  = 3'd1;
    localparam logic [2:0] OP_COMPLETE = 3'd2;
    localparam logic [2:0] OP_CANCEL   = 3'd3;
    localparam logic [2:0] OP_RELEASE  = 3'd4;
    localparam logic [2:0] OP_STATE    = 3'd5;
    localparam logic [2:0] OP_COMPL_Q  = 3'd6;
    localparam logic [2:0] OP_SPAN     = 3'd7;

    localparam logic [2:0] ST_FREE = 3'd0;
    localparam logic [2:0] ST_CPU  = 3'd1;
    localparam logic [2:0] ST_DEV  = 3'd2;
    localparam logic [2:0] ST_DONE = 3'd3;
    localparam logic [2:0] ST_FAIL = 3'd4;
    localparam logic [2:0] ST_REL  = 3'd5;

    localparam logic [0:0] REG_OWNER = 1'd0;
    localparam logic [0:0] REG_READY = 1'd1;

    typedef struct packed {
        logic [63:0] gen;
        logic [2:0]  st;
        logic        retired;
        logic [16:0] req;
        logic [16:0] moved;
        logic        dir;
    } slot_ent_t;

    typedef struct packed {
        logic        ok;
        logic [4:0]  slot_index;
        logic [63:0] out_token;
        logic [63:0] out_gen;
        logic [2:0]  slot_state;
        logic [16:0] out_len;
        logic        out_success;
        logic [31:0] slot_addr;
        logic [16:0] out_request;
        logic        out_dir;
    } result_t;

    function automatic logic [31:0] slot_address(input logic [SLOT_W-1:0] i);
        logic [63:0] a;
        a = {32'd0, ARENA_BASE} + 64'(i) * 64'(SLOT_BYTES);
        return a[31:0];
    endfunction

endpackage

/* hdl/dma_slot_ownership_tracker_core.sv */
// Top level of the DMA slot ownership tracker.
// Handle operations read the addressed slot, then update it and register the result;
// acquire scans the slots in order, one slot memory read per cycle of the scan.
// One beat is in work at a time; the next beat is taken the cycle after the result is taken.
// Reset (and the ready register rising) runs a reload sweep through every slot of the
// slot memory; no beat is taken then.
module dma_slot_ownership_tracker_core import dsot_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [0:0]   cfg_addr,
    input  logic [31:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // opcode, controller_in, req_core, request_len, xfer_dir, handle_token,
    // handle_gen, handle_pad, done_len, done_ok; 233 bits, zero to 240
    input  logic [239:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // ok, slot_index, out_token, out_gen, slot_state, out_len, out_success,
    // slot_addr, out_request, out_dir; 205 bits, zero to 208
    output logic [207:0] m_tdata
);
    result_t   res;
    logic      ram_we;
    logic [SLOT_W-1:0] ram_waddr, ram_raddr;
    slot_ent_t ram_wdata, ram_rdata;

    dsot_ctrl u_ctrl (
        .aclk, .aresetn, .cfg_we, .cfg_addr, .cfg_data,
        .in_valid(s_tvalid), .in_ready(s_tready),
        .opcode(s_tdata[2:0]), .controller_in(s_tdata[34:3]),
        .req_core(s_tdata[36:35]), .request_len(s_tdata[53:37]),
        .xfer_dir(s_tdata[54]), .handle_token(s_tdata[118:55]),
        .handle_gen(s_tdata[182:119]), .handle_pad(s_tdata[214:183]),
        .done_len(s_tdata[231:215]), .done_ok(s_tdata[232]),
        .res_valid(m_tvalid), .res_ready(m_tready), .res,
        .ram_we, .ram_waddr, .ram_wdata, .ram_raddr, .ram_rdata
    );

    dsot_slot_ram u_ram (
        .aclk, .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
        .raddr(ram_raddr), .rdata(ram_rdata)
    );

    assign m_tdata = {3'd0, res.out_dir, res.out_request, res.slot_addr, res.out_success,
                      res.out_len, res.slot_state, res.out_gen, res.out_token,
                      res.slot_index, res.ok};
endmodule

/* hdl/dsot_slot_ram.sv */
// Slot record memory: one write port, one registered read port.
module dsot_slot_ram import dsot_pkg::*; (
    input  logic              aclk,
    input  logic              we,
    input  logic [SLOT_W-1:0] waddr,
    input  slot_ent_t         wdata,
    input  logic [SLOT_W-1:0] raddr,
    output slot_ent_t         rdata
);
    slot_ent_t mem [SLOT_COUNT];

    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

/* hdl/dsot_ctrl.sv */
// Sequencer: reload sweep, free-slot scan and read-modify-write of one slot.
module dsot_ctrl import dsot_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [0:0]        cfg_addr,
    input  logic [31:0]       cfg_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [2:0]        opcode,
    input  logic [31:0]       controller_in,
    input  logic [1:0]        req_core,
    input  logic [16:0]       request_len,
    input  logic              xfer_dir,
    input  logic [63:0]       handle_token,
    input  logic [63:0]       handle_gen,
    input  logic [31:0]       handle_pad,
    input  logic [16:0]       done_len,
    input  logic              done_ok,
    output logic              res_valid,
    input  logic              res_ready,
    output result_t           res,
    output logic              ram_we,
    output logic [SLOT_W-1:0] ram_waddr,
    output slot_ent_t         ram_wdata,
    output logic [SLOT_W-1:0] ram_raddr,
    input  slot_ent_t         ram_rdata
);
    localparam logic [2:0] S_INIT = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_READ = 3'd2;
    localparam logic [2:0] S_EXEC = 3'd3;
    localparam logic [2:0] S_SCAN = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [31:0]       owner_reg;
    logic              ready_reg;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic              res_valid_reg;
    result_t           res_reg;

    logic [2:0]  op_q;
    logic        own_q;
    logic        hdl_q;
    logic [16:0] len_q;
    logic        dir_q;
    logic [63:0] gen_q;
    logic [16:0] dlen_q;
    logic        dok_q;

    logic        owner_ok, len_ok, tok_ok;
    logic [SLOT_W-1:0] cur;
    logic        gen_hit;
    result_t     r;
    slot_ent_t   w;
    logic        wr;

    assign owner_ok = (req_core == 2'(HOST_CORE)) && (controller_in != 32'd0) &&
                      ready_reg && (owner_reg == controller_in);
    assign len_ok = (request_len != 17'd0) && (32'(request_len) <= 32'(SLOT_BYTES)) &&
                    (request_len[ALIGN_W-1:0] == '0 || ALIGN_BYTES == 1);
    assign tok_ok = ((handle_token >> TOKEN_SHIFT) == 64'(TOKEN_MAGIC)) &&
                    ((handle_token & ((64'd1 << TOKEN_SHIFT) - 64'd1)) < 64'(SLOT_COUNT));
    assign cur = idx_reg[SLOT_W-1:0];

    assign in_ready  = (state_reg == S_IDLE) && !res_valid_reg;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign gen_hit   = ram_rdata.gen == gen_q;

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        ram_raddr  = cur;
        wr         = 1'b0;
        w          = ram_rdata;
        r          = '0;
        case (state_reg)
            S_INIT: begin
                wr = 1'b1;
                w  = '{gen: 64'(idx_reg) + 64'd1, st: ST_FREE, retired: 1'b0,
                       req: '0, moved: '0, dir: 1'b0};
                if (idx_reg == CNT_W'(SLOT_COUNT - 1)) begin
                    state_next = S_IDLE;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_IDLE: begin
                if (in_valid && in_ready) begin
                    idx_next = (opcode == OP_ACQUIRE) ? '0
                             : CNT_W'(handle_token[SLOT_W-1:0]);
                    ram_raddr = (opcode == OP_ACQUIRE) ? '0 : handle_token[SLOT_W-1:0];
                    state_next = (opcode == OP_ACQUIRE) ? S_SCAN : S_EXEC;
                end
            end
            S_SCAN: begin
                // ram_rdata holds slot idx_reg
                if (!own_q) begin
                    state_next = S_READ;
                end else if (ram_rdata.st == ST_FREE && !ram_rdata.retired) begin
                    wr = 1'b1;
                    w.st = ST_CPU; w.req = len_q; w.dir = dir_q; w.moved = '0;
                    r.ok = 1'b1;
                    r.slot_index = 5'(cur);
                    r.out_token = (64'(TOKEN_MAGIC) << TOKEN_SHIFT) | 64'(cur);
                    r.out_gen = ram_rdata.gen;
                    r.slot_state = ST_CPU;
                    r.slot_addr = slot_address(cur);
                    r.out_request = len_q;
                    r.out_dir = dir_q;
                    state_next = S_READ;
                end else if (idx_reg == CNT_W'(SLOT_COUNT - 1)) begin
                    state_next = S_READ;
                end else begin
                    idx_next = idx_reg + 1'b1;
                    ram_raddr = SLOT_W'(idx_reg + 1'b1);
                end
            end
            S_EXEC: begin
                if (hdl_q && gen_hit && ram_rdata.st != ST_FREE && ram_rdata.st != ST_REL) begin
                    r.ok = 1'b1;
                    case (op_q)
                        OP_PUBLISH: begin
                            if (ram_rdata.st == ST_CPU) begin
                                wr = 1'b1; w.st = ST_DEV;
                            end else r.ok = 1'b0;
                        end
                        OP_COMPLETE: begin
                            if (ram_rdata.st == ST_DEV && dlen_q <= ram_rdata.req) begin
                                wr = 1'b1; w.moved = dlen_q;
                                w.st = dok_q ? ST_DONE : ST_FAIL;
                            end else r.ok = 1'b0;
                        end
                        OP_CANCEL: begin
                            if (ram_rdata.st == ST_CPU) begin
                                wr = 1'b1; w.st = ST_FAIL;
                            end else r.ok = 1'b0;
                        end
                        OP_RELEASE: begin
                            if (ram_rdata.st == ST_CPU || ram_rdata.st == ST_DONE ||
                                ram_rdata.st == ST_FAIL) begin
                                wr = 1'b1; w.req = '0; w.moved = '0; w.dir = 1'b0;
                                if (&ram_rdata.gen) begin
                                    w.retired = 1'b1; w.st = ST_REL;
                                end else begin
                                    w.gen = ram_rdata.gen + 64'd1; w.st = ST_FREE;
                                end
                            end else r.ok = 1'b0;
                        end
                        OP_COMPL_Q: begin
                            if (ram_rdata.st == ST_DONE || ram_rdata.st == ST_FAIL) begin
                                r.out_len = ram_rdata.moved;
                                r.out_success = ram_rdata.st == ST_DONE;
                            end else r.ok = 1'b0;
                        end
                        OP_SPAN: begin
                            r.out_gen = ram_rdata.gen;
                            r.slot_addr = slot_address(cur);
                            r.out_request = ram_rdata.req;
                            r.out_dir = ram_rdata.dir;
                        end
                        default: ;
                    endcase
                    if (r.ok) begin
                        r.slot_index = 5'(cur);
                        r.slot_state = wr ? w.st : ram_rdata.st;
                    end else begin
                        r = '0;
                        wr = 1'b0;
                    end
                end
                state_next = S_READ;
            end
            S_READ: state_next = S_IDLE;  // write-back settles
            default: state_next = S_IDLE;
        endcase
    end

    assign ram_we    = wr;
    assign ram_waddr = cur;
    assign ram_wdata = w;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_INIT;
            idx_reg       <= '0;
            owner_reg     <= '0;
            ready_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            if (cfg_we && cfg_addr == REG_OWNER) owner_reg <= cfg_data;
            if (cfg_we && cfg_addr == REG_READY) begin
                ready_reg <= cfg_data[0];
                if (cfg_data[0] && !ready_reg) begin
                    state_reg <= S_INIT;
                    idx_reg   <= '0;
                end
            end
            if (res_valid_reg && res_ready) res_valid_reg <= 1'b0;
            if (state_reg == S_EXEC || (state_reg == S_SCAN && state_next == S_READ))
                res_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_EXEC || (state_reg == S_SCAN && state_next == S_READ))
            res_reg <= r;
        if (in_valid && in_ready) begin
            op_q   <= opcode;
            own_q  <= owner_ok && len_ok;
            hdl_q  <= owner_ok && (handle_pad == 32'd0) && (handle_gen != 64'd0) && tok_ok;
            len_q  <= request_len;
            dir_q  <= xfer_dir;
            gen_q  <= handle_gen;
            dlen_q <= done_len;
            dok_q  <= done_ok;
        end
    end
endmodule

/* hdl/dsot_checker.sv */
// Port-level checks for the tracker, bound to the top level.
module dsot_port_props (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [207:0] m_tdata
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat dropped or changed under stall");
    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second beat taken while one is in work");
    a_rej: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[207:1] == '0)
        else $error("rejected result has nonzero fields");
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("beat taken while result pending");
endmodule

bind dma_slot_ownership_tracker_core dsot_port_props u_chk (
    .aclk, .aresetn, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .m_tdata
);
